### rtl/core/rltg_pkg.sv
// Shared types, constants and helpers for the three-gate lifetime block.
`timescale 1ns / 1ps
package rltg_pkg;

    localparam int COUNT_BITS = 16;
    localparam int SUM_W      = 27;
    localparam int POS_W      = 13;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [63:0] CAP     = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LN2_Q26 = 64'd46516320;
    localparam logic [63:0] POS48   = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] NEG48   = 64'h0000_8000_0000_0000;

    localparam logic [7:0] CFG_START_BIN    = 8'd0;
    localparam logic [7:0] CFG_GATE_BINS    = 8'd1;
    localparam logic [7:0] CFG_GATE_TIME    = 8'd2;
    localparam logic [7:0] CFG_TIME_PER_BIN = 8'd3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EQUAL = 2'd1,
        ST_QBAD  = 2'd2,
        ST_SHORT = 2'd3
    } t_status;

    typedef struct packed {
        logic [11:0] start_bin;
        logic [10:0] gate_bins;
        logic [31:0] gate_time;
        logic [31:0] time_per_bin;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] a1;
        logic [SUM_W-1:0] a2;
        logic [SUM_W-1:0] a3;
        logic             short_tr;
    } t_job;

    typedef struct packed {
        logic        start;
        logic        div;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } t_md_req;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
        logic [63:0]  quot;
    } t_md_rsp;

    typedef enum logic [2:0] {
        E_IDLE,
        E_MUL,
        E_CHK,
        E_DIV,
        E_FIN
    } t_eng_state;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_NORM,
        S_LOG,
        S_LN,
        S_LNCHK,
        S_TAU,
        S_IO1,
        S_IO2,
        S_IO3,
        S_IO4,
        S_B1T,
        S_B1M,
        S_B2T,
        S_B2M,
        S_OUT
    } t_back_state;

    // Clamp a magnitude and apply its sign into 48-bit two's complement.
    function automatic logic [47:0] sat48(input logic neg, input logic [63:0] mag);
        logic [63:0] m;
        if (neg) begin
            m = (mag > NEG48) ? NEG48 : mag;
            sat48 = 48'(64'd0 - m);
        end else begin
            sat48 = (mag > POS48) ? POS48[47:0] : mag[47:0];
        end
    endfunction

endpackage

### rtl/core/rapid_lifetime_three_gate.sv
// Top level of the three-gate rapid lifetime block: config registers and wiring.
`timescale 1ns / 1ps
// Usage:
//   Histogram bins enter on the push/full queue port, one per cycle, bins of a
//   pixel in arrival order; last_bin marks the final bin and closes the pixel.
//   One result per pixel appears on the output queue port (empty/pop); it
//   stays on the ports until popped.
//   Registers are written through the cfg channel (valid/ready, ready always
//   high): 0 start_bin, 1 gate_bins, 2 gate_time, 3 time_per_bin. Other
//   indexes are ignored.
//   Throughput: one bin per cycle while the pixel queue has room. The back
//   end takes one pixel at a time; its time per pixel is set by the single
//   shared 32x32 multiply and 64-step divide unit that runs 64 log squarings
//   and nine wide quotients (shorter when a quotient saturates early). Two
//   closed pixels can wait in the queue; when it is full, full stays high
//   until the back end takes the next pixel.
//   If the receiver does not pop, the back end holds its finished result and
//   stalls; bins keep flowing until the pixel queue fills.
//   Reset clears the bin counter, gate sums, queues and loads register
//   defaults; no clearing pass is needed.
module rapid_lifetime_three_gate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_bin_count,
    input  logic        i_last_bin,
    output logic        empty,
    input  logic        pop,
    output logic [47:0] o_lifetime,
    output logic [47:0] o_amplitude,
    output logic [47:0] o_background_first,
    output logic [47:0] o_background_second,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import rltg_pkg::*;

    t_cfg    r_cfg;
    t_job    job_in, job_out;
    t_md_req md_req;
    t_md_rsp md_rsp;
    logic    accept, job_push, job_pop, job_empty;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_bin    <= 12'd0;
            r_cfg.gate_bins    <= 11'd16;
            r_cfg.gate_time    <= 32'd40960000;
            r_cfg.time_per_bin <= 32'd2560000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_START_BIN:    r_cfg.start_bin    <= i_cfg_data[11:0];
                CFG_GATE_BINS:    r_cfg.gate_bins    <= i_cfg_data[10:0];
                CFG_GATE_TIME:    r_cfg.gate_time    <= i_cfg_data;
                CFG_TIME_PER_BIN: r_cfg.time_per_bin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rltg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_bin_count (i_bin_count),
        .i_last_bin  (i_last_bin),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    rltg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (job_empty)
    );

    rltg_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    rltg_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_job_empty         (job_empty),
        .i_job               (job_out),
        .o_job_pop           (job_pop),
        .o_md_req            (md_req),
        .i_md_rsp            (md_rsp),
        .i_pop               (pop),
        .o_empty             (empty),
        .o_lifetime          (o_lifetime),
        .o_amplitude         (o_amplitude),
        .o_background_first  (o_background_first),
        .o_background_second (o_background_second),
        .o_status            (o_status)
    );

endmodule

### rtl/core/rltg_muldiv.sv
// Shared mul/div unit: 128-bit product in four steps; if div, then restoring division.
`timescale 1ns / 1ps
module rltg_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rltg_pkg::t_md_req i_req,
    output rltg_pkg::t_md_rsp o_rsp
);
    import rltg_pkg::*;

    t_eng_state   r_state, n_state;
    logic [63:0]  r_a, r_b, r_c, r_hi, r_lo, r_q;
    logic [127:0] r_prod;
    logic [5:0]   r_k;
    logic         r_div;
    logic [31:0]  ai, bi;
    logic [63:0]  pp, hs;
    logic [127:0] pp_sh;
    logic         ovf, carry, take;

    assign ai    = r_k[0] ? r_a[63:32] : r_a[31:0];
    assign bi    = r_k[1] ? r_b[63:32] : r_b[31:0];
    assign pp    = 64'(ai) * 64'(bi);
    assign ovf   = (r_c == 64'd0) || (r_prod[127:64] >= r_c);
    assign carry = r_hi[63];
    assign hs    = {r_hi[62:0], r_lo[63]};
    assign take  = carry || (hs >= r_c);

    always_comb begin
        case (r_k[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            E_IDLE: if (i_req.start) n_state = E_MUL;
            E_MUL:  if (r_k[1:0] == 2'd3) n_state = E_CHK;
            E_CHK: begin
                if (!r_div || ovf) n_state = E_FIN;
                else n_state = E_DIV;
            end
            E_DIV:  if (r_k == 6'd63) n_state = E_FIN;
            E_FIN:  n_state = E_IDLE;
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            E_IDLE: begin
                if (i_req.start) begin
                    r_a    <= i_req.a;
                    r_b    <= i_req.b;
                    r_c    <= i_req.c;
                    r_div  <= i_req.div;
                    r_prod <= 128'd0;
                    r_k    <= 6'd0;
                end
            end
            E_MUL: begin
                r_prod <= r_prod + pp_sh;
                r_k    <= (r_k[1:0] == 2'd3) ? 6'd0 : r_k + 6'd1;
            end
            E_CHK: begin
                r_hi <= r_prod[127:64];
                r_lo <= r_prod[63:0];
                r_q  <= ovf ? CAP : 64'd0;
                r_k  <= 6'd0;
            end
            E_DIV: begin
                r_hi <= take ? hs - r_c : hs;
                r_q  <= {r_q[62:0], take};
                r_lo <= {r_lo[62:0], 1'b0};
                r_k  <= r_k + 6'd1;
            end
            default: ;
        endcase
    end

    assign o_rsp.done = (r_state == E_FIN);
    assign o_rsp.prod = r_prod;
    assign o_rsp.quot = (r_q > CAP) ? CAP : r_q;

endmodule

### rtl/core/rltg_front.sv
// Front end: counts bins, sums the three gates and hands a finished pixel on.
`timescale 1ns / 1ps
module rltg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rltg_pkg::t_cfg      i_cfg,
    input  logic                i_accept,
    input  logic [15:0]         i_bin_count,
    input  logic                i_last_bin,
    output logic                o_job_push,
    output rltg_pkg::t_job      o_job
);
    import rltg_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos, off, g1, g2, g3;
    logic [SUM_W-1:0] r_s1, r_s2, r_s3, n_s1, n_s2, n_s3;
    logic             ge, sel1, sel2, sel3;
    logic [SUM_W:0]   cnt;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [SUM_W:0] c);
        logic [SUM_W:0] t;
        t = {1'b0, s} + c;
        sat_add = t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction

    always_comb begin
        cnt   = (SUM_W+1)'(i_bin_count[COUNT_BITS-1:0]);
        g1    = POS_W'(i_cfg.gate_bins);
        g2    = POS_W'({i_cfg.gate_bins, 1'b0});
        g3    = g1 + g2;
        ge    = r_pos >= POS_W'(i_cfg.start_bin);
        off   = r_pos - POS_W'(i_cfg.start_bin);
        sel1  = ge && (off < g1);
        sel2  = ge && !sel1 && (off < g2);
        sel3  = ge && !sel1 && !sel2 && (off < g3);
        n_s1  = sel1 ? sat_add(r_s1, cnt) : r_s1;
        n_s2  = sel2 ? sat_add(r_s2, cnt) : r_s2;
        n_s3  = sel3 ? sat_add(r_s3, cnt) : r_s3;
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
        o_job.a1       = n_s1;
        o_job.a2       = n_s2;
        o_job.a3       = n_s3;
        o_job.short_tr = {1'b0, n_pos} < (14'(i_cfg.start_bin) + 14'(g3));
        o_job_push     = i_accept && i_last_bin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_s1  <= '0;
            r_s2  <= '0;
            r_s3  <= '0;
        end else if (i_accept) begin
            // the last bin closes the pixel: start the next one from zero
            if (i_last_bin) begin
                r_pos <= '0;
                r_s1  <= '0;
                r_s2  <= '0;
                r_s3  <= '0;
            end else begin
                r_pos <= n_pos;
                r_s1  <= n_s1;
                r_s2  <= n_s2;
                r_s3  <= n_s3;
            end
        end
    end

endmodule

### rtl/core/rltg_queue.sv
// Two-entry queue of finished pixels between front and back.
`timescale 1ns / 1ps
module rltg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rltg_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output rltg_pkg::t_job o_job,
    output logic           o_empty
);
    import rltg_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

### rtl/core/rltg_back.sv
// Back end: logarithms, quotients and saturation for one pixel at a time.
`timescale 1ns / 1ps
module rltg_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rltg_pkg::t_cfg    i_cfg,
    input  logic              i_job_empty,
    input  rltg_pkg::t_job    i_job,
    output logic              o_job_pop,
    output rltg_pkg::t_md_req o_md_req,
    input  rltg_pkg::t_md_rsp i_md_rsp,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [47:0]       o_lifetime,
    output logic [47:0]       o_amplitude,
    output logic [47:0]       o_background_first,
    output logic [47:0]       o_background_second,
    output logic [1:0]        o_status
);
    import rltg_pkg::*;

    t_back_state r_state, n_state;
    t_job        r_job;
    t_status     r_status, chk_status;
    logic        r_issued, r_ov, r_which, r_lnneg, r_d12neg, r_dneg, r_xneg;
    logic [26:0] r_m12, r_m23;
    logic [53:0] r_pm12, r_pm23;
    logic [28:0] r_ddmag;
    logic [32:0] r_x, y, x_next;
    logic [4:0]  r_e, r_cnt;
    logic [31:0] r_frac, frac_next;
    logic [36:0] r_l1, r_l2, lmag;
    logic [37:0] r_lnm;
    logic [63:0] r_tm, r_xmag, w, xmag;
    logic [47:0] r_tau, r_io, r_b1, r_b2;
    logic signed [27:0] d12, d23;
    logic signed [28:0] dd;
    logic [27:0] m12w, m23w;
    logic [65:0] xa, xs;
    logic        op_state, op_done;
    logic [63:0] ln_sum;

    always_comb begin
        d12  = 28'(r_job.a1) - 28'(r_job.a2);
        d23  = 28'(r_job.a2) - 28'(r_job.a3);
        dd   = {d12[27], d12} - {d23[27], d23};
        m12w = d12[27] ? 28'(-d12) : d12;
        m23w = d23[27] ? 28'(-d23) : d23;
        if (r_job.short_tr) chk_status = ST_SHORT;
        else if (r_job.a1 == r_job.a2) chk_status = ST_EQUAL;
        else if (d23 == 28'sd0 || d12[27] != d23[27] || d12 == d23) chk_status = ST_QBAD;
        else chk_status = ST_OK;
        w         = (i_cfg.gate_time == 32'd0) ? 64'd1 : 64'(i_cfg.gate_time);
        lmag      = (r_l1 > r_l2) ? r_l1 - r_l2 : r_l2 - r_l1;
        y         = i_md_rsp.prod[63:31];
        x_next    = y[32] ? {1'b0, y[32:1]} : y;
        frac_next = r_frac | (y[32] ? (32'd1 << r_cnt) : 32'd0);
        ln_sum    = i_md_rsp.prod[63:0] + 64'h0000_0000_0200_0000;
        xa        = {23'd0, (r_state == S_B1T) ? r_job.a1 : r_job.a2, 16'd0};
        // add the term when the denominator is negative, subtract otherwise
        xs        = r_dneg ? xa + {2'b0, i_md_rsp.quot} : xa - {2'b0, i_md_rsp.quot};
        xmag      = xs[65] ? 64'(-xs) : xs[63:0];
    end

    // operand select for the shared unit
    always_comb begin
        o_md_req.div = 1'b1;
        o_md_req.a   = 64'd0;
        o_md_req.b   = 64'd0;
        o_md_req.c   = 64'd1;
        op_state     = 1'b1;
        case (r_state)
            S_LOG: begin
                o_md_req.div = 1'b0;
                o_md_req.a   = 64'(r_x[31:0]);
                o_md_req.b   = 64'(r_x[31:0]);
            end
            S_LN: begin
                o_md_req.div = 1'b0;
                o_md_req.a   = 64'(lmag);
                o_md_req.b   = LN2_Q26;
            end
            S_TAU: begin
                o_md_req.a = w;
                o_md_req.b = 64'h0000_0001_0000_0000;
                o_md_req.c = 64'(r_lnm);
            end
            S_IO1: begin
                o_md_req.a = 64'(i_cfg.time_per_bin);
                o_md_req.b = 64'(r_m12);
                o_md_req.c = w;
            end
            S_IO2: begin
                o_md_req.a = r_tm;
                o_md_req.b = 64'(r_lnm);
                o_md_req.c = 64'h0000_0001_0000_0000;
            end
            S_IO3, S_IO4: begin
                o_md_req.a = r_tm;
                o_md_req.b = 64'(r_m12);
                o_md_req.c = 64'(r_ddmag);
            end
            S_B1T, S_B2T: begin
                o_md_req.a = (r_state == S_B1T) ? 64'(r_pm12) : 64'(r_pm23);
                o_md_req.b = 64'd65536;
                o_md_req.c = 64'(r_ddmag);
            end
            S_B1M, S_B2M: begin
                o_md_req.a = r_xmag;
                o_md_req.b = 64'(i_cfg.time_per_bin);
                o_md_req.c = w;
            end
            default: op_state = 1'b0;
        endcase
        o_md_req.start = op_state && !r_issued;
        op_done        = op_state && r_issued && i_md_rsp.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: n_state = (chk_status == ST_OK) ? S_NORM : S_OUT;
            S_NORM:  if (r_x[31]) n_state = S_LOG;
            S_LOG: begin
                if (op_done && r_cnt == 5'd0) n_state = r_which ? S_LN : S_NORM;
            end
            S_LN:    if (op_done) n_state = S_LNCHK;
            S_LNCHK: n_state = (r_lnm == 38'd0) ? S_OUT : S_TAU;
            S_TAU:   if (op_done) n_state = S_IO1;
            S_IO1:   if (op_done) n_state = S_IO2;
            S_IO2:   if (op_done) n_state = S_IO3;
            S_IO3:   if (op_done) n_state = S_IO4;
            S_IO4:   if (op_done) n_state = S_B1T;
            S_B1T:   if (op_done) n_state = S_B1M;
            S_B1M:   if (op_done) n_state = S_B2T;
            S_B2T:   if (op_done) n_state = S_B2M;
            S_B2M:   if (op_done) n_state = S_OUT;
            S_OUT:   if (!r_ov) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (o_md_req.start) r_issued <= 1'b1;
            else if (op_done)   r_issued <= 1'b0;
            if (r_state == S_OUT && !r_ov) r_ov <= 1'b1;
            else if (i_pop && r_ov)        r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (!i_job_empty) r_job <= i_job;
            S_CHECK: begin
                r_status <= chk_status;
                r_m12    <= m12w[26:0];
                r_m23    <= m23w[26:0];
                r_pm12   <= 54'(m12w[26:0]) * 54'(m12w[26:0]);
                r_pm23   <= 54'(m23w[26:0]) * 54'(m12w[26:0]);
                r_ddmag  <= dd[28] ? 29'(-dd) : dd;
                r_dneg   <= dd[28];
                r_d12neg <= d12[27];
                r_lnneg  <= m23w < m12w;
                r_x      <= 33'(m12w);
                r_e      <= 5'd31;
                r_which  <= 1'b0;
            end
            S_NORM: begin
                if (r_x[31]) begin
                    r_cnt  <= 5'd31;
                    r_frac <= 32'd0;
                end else begin
                    r_x <= {r_x[31:0], 1'b0};
                    r_e <= r_e - 5'd1;
                end
            end
            S_LOG: begin
                if (op_done) begin
                    r_x    <= x_next;
                    r_frac <= frac_next;
                    r_cnt  <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        if (r_which) begin
                            r_l2 <= {r_e, frac_next};
                        end else begin
                            r_l1    <= {r_e, frac_next};
                            r_x     <= 33'(r_m23);
                            r_e     <= 5'd31;
                            r_which <= 1'b1;
                        end
                    end
                end
            end
            S_LN:    if (op_done) r_lnm <= ln_sum[63:26];
            S_LNCHK: if (r_lnm == 38'd0) r_status <= ST_QBAD;
            S_TAU:   if (op_done) r_tau <= sat48(!r_lnneg, i_md_rsp.quot);
            S_IO1, S_IO2, S_IO3: if (op_done) r_tm <= i_md_rsp.quot;
            S_IO4:   if (op_done) r_io <= sat48(!(r_d12neg != r_lnneg), i_md_rsp.quot);
            S_B1T, S_B2T: begin
                if (op_done) begin
                    r_xneg <= xs[65];
                    r_xmag <= xmag;
                end
            end
            S_B1M:   if (op_done) r_b1 <= sat48(r_xneg, i_md_rsp.quot);
            S_B2M:   if (op_done) r_b2 <= sat48(r_xneg, i_md_rsp.quot);
            S_OUT: begin
                if (!r_ov) begin
                    // error results carry zeros in every numeric field
                    o_status            <= r_status;
                    o_lifetime          <= (r_status == ST_OK) ? r_tau : 48'd0;
                    o_amplitude         <= (r_status == ST_OK) ? r_io : 48'd0;
                    o_background_first  <= (r_status == ST_OK) ? r_b1 : 48'd0;
                    o_background_second <= (r_status == ST_OK) ? r_b2 : 48'd0;
                end
            end
            default: ;
        endcase
    end

    assign o_empty = !r_ov;

endmodule
